/* sv/lli_pkg.sv */
// Package for the line-line intersection block: payload types, width constants
// and the per-stage record of the divider chain. No dependencies.
`default_nettype none

package lli_pkg;

  localparam int CoordBits = 16;
  localparam int DiffBits  = CoordBits + 1;
  localparam int CrossBits = 2 * CoordBits + 2;       // signed cross product
  localparam int MagBits   = 2 * CoordBits + 1;       // magnitude of cross product
  localparam int LoBits    = (MagBits + 1) / 2;       // low slice of the numerator
  localparam int HiBits    = MagBits - LoBits;
  localparam int ProdBits  = CoordBits + MagBits;     // |dir| * |num|, quotient width

  typedef struct packed {
    logic signed [CoordBits-1:0] first_start_x;
    logic signed [CoordBits-1:0] first_start_y;
    logic signed [CoordBits-1:0] first_end_x;
    logic signed [CoordBits-1:0] first_end_y;
    logic signed [CoordBits-1:0] second_start_x;
    logic signed [CoordBits-1:0] second_start_y;
    logic signed [CoordBits-1:0] second_end_x;
    logic signed [CoordBits-1:0] second_end_y;
  } in_t;

  typedef struct packed {
    logic              found;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
    logic              clipped;
  } out_t;

  // One entry of the divider chain: both coordinates share the divisor.
  typedef struct packed {
    logic [ProdBits-1:0]         num_x;
    logic [ProdBits-1:0]         num_y;
    logic [MagBits-1:0]          rem_x;
    logic [MagBits-1:0]          rem_y;
    logic [ProdBits-1:0]         quo_x;
    logic [ProdBits-1:0]         quo_y;
    logic [MagBits-1:0]          den;
    logic                        neg_x;
    logic                        neg_y;
    logic signed [CoordBits-1:0] base_x;
    logic signed [CoordBits-1:0] base_y;
    logic                        found;
  } div_t;

endpackage

`default_nettype wire

/* sv/line_line_intersection.sv */
// Top level of the line-line intersection block: front-end arithmetic, the
// divider chain of lli_div_stage instances and the rounding/saturation back end.
// Depends on lli_pkg and lli_div_stage.
//
// Usage: a transaction on the input side is accepted at a rising edge where
// start_i is high and busy_o is low. busy_o is always low, so a new line pair
// can be issued in every cycle. Each transaction produces exactly one result
// transaction: out_o is valid for one cycle with valid_o high.
//
// The pipeline is one input register, registers for the differences, the cross
// products, the split |dir| * |num| partial products and the chain entry, one
// quotient bit per divider stage (ProdBits stages), then a rounding stage and a
// saturation/output stage. Throughput is one transaction per cycle; the chain
// of divider stages sets the latency.
//
// Reset clears only the valid bits of the pipeline, so no result is emitted
// after reset until a new transaction arrives. The receiver cannot stall:
// results are never held back.
`default_nettype none

module line_line_intersection (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire lli_pkg::in_t in_i,
  output logic              busy_o,
  output logic              valid_o,
  output lli_pkg::out_t     out_o
);

  localparam int C  = lli_pkg::CoordBits;
  localparam int DB = lli_pkg::DiffBits;
  localparam int CB = lli_pkg::CrossBits;
  localparam int MB = lli_pkg::MagBits;
  localparam int LB = lli_pkg::LoBits;
  localparam int HB = lli_pkg::HiBits;
  localparam int PB = lli_pkg::ProdBits;
  localparam int SumBits = ((PB + 1 > 41) ? PB + 1 : 41) + 2;
  localparam int Latency = PB + 7;

  localparam logic [SumBits-1:0]        QLimit = SumBits'(1) << 40;
  localparam logic signed [SumBits-1:0] SatMax = SumBits'(64'sd2147483647);
  localparam logic signed [SumBits-1:0] SatMin = SumBits'(-64'sd2147483648);

  assign busy_o = 1'b0;

  // Input register.
  logic          v0_q;
  lli_pkg::in_t  in_q;

  // Differences.
  logic                 v1_q;
  logic signed [DB-1:0] d1x_q, d1y_q, d2x_q, d2y_q, wx_q, wy_q;
  logic signed [C-1:0]  bx1_q, by1_q;

  // Cross products.
  logic                 v2_q;
  logic signed [CB-1:0] cr_q, nm_q;
  logic signed [DB-1:0] dx2_q, dy2_q;
  logic signed [C-1:0]  bx2_q, by2_q;

  // Partial products.
  logic                 v3_q;
  logic [C+LB-1:0]      plx_q, ply_q;
  logic [C+HB-1:0]      phx_q, phy_q;
  logic [MB-1:0]        den3_q;
  logic                 ngx3_q, ngy3_q, fnd3_q;
  logic signed [C-1:0]  bx3_q, by3_q;

  // Chain entry.
  logic                 v4_q;
  lli_pkg::div_t        ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Magnitudes for the partial-product stage.
  logic [DB-1:0] dxm, dym;
  logic [CB-1:0] nmm, crm;
  always_comb begin
    dxm = dx2_q[DB-1] ? DB'(-dx2_q) : DB'(dx2_q);
    dym = dy2_q[DB-1] ? DB'(-dy2_q) : DB'(dy2_q);
    nmm = nm_q[CB-1] ? CB'(-nm_q) : CB'(nm_q);
    crm = cr_q[CB-1] ? CB'(-cr_q) : CB'(cr_q);
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_i;

    d1x_q <= DB'(in_q.first_end_x) - DB'(in_q.first_start_x);
    d1y_q <= DB'(in_q.first_end_y) - DB'(in_q.first_start_y);
    d2x_q <= DB'(in_q.second_end_x) - DB'(in_q.second_start_x);
    d2y_q <= DB'(in_q.second_end_y) - DB'(in_q.second_start_y);
    wx_q  <= DB'(in_q.second_start_x) - DB'(in_q.first_start_x);
    wy_q  <= DB'(in_q.second_start_y) - DB'(in_q.first_start_y);
    bx1_q <= in_q.first_start_x;
    by1_q <= in_q.first_start_y;

    cr_q  <= CB'(d1x_q) * CB'(d2y_q) - CB'(d1y_q) * CB'(d2x_q);
    nm_q  <= CB'(wx_q) * CB'(d2y_q) - CB'(wy_q) * CB'(d2x_q);
    dx2_q <= d1x_q;
    dy2_q <= d1y_q;
    bx2_q <= bx1_q;
    by2_q <= by1_q;

    // The numerator magnitude is split so each multiplier stays narrow.
    plx_q  <= (C+LB)'(dxm[C-1:0]) * (C+LB)'(nmm[LB-1:0]);
    ply_q  <= (C+LB)'(dym[C-1:0]) * (C+LB)'(nmm[LB-1:0]);
    phx_q  <= (C+HB)'(dxm[C-1:0]) * (C+HB)'(nmm[MB-1:LB]);
    phy_q  <= (C+HB)'(dym[C-1:0]) * (C+HB)'(nmm[MB-1:LB]);
    den3_q <= crm[MB-1:0];
    ngx3_q <= dx2_q[DB-1] ^ nm_q[CB-1] ^ cr_q[CB-1];
    ngy3_q <= dy2_q[DB-1] ^ nm_q[CB-1] ^ cr_q[CB-1];
    fnd3_q <= cr_q != '0;
    bx3_q  <= bx2_q;
    by3_q  <= by2_q;

    ent_q.num_x  <= (PB'(phx_q) << LB) + PB'(plx_q);
    ent_q.num_y  <= (PB'(phy_q) << LB) + PB'(ply_q);
    ent_q.rem_x  <= '0;
    ent_q.rem_y  <= '0;
    ent_q.quo_x  <= '0;
    ent_q.quo_y  <= '0;
    ent_q.den    <= den3_q;
    ent_q.neg_x  <= ngx3_q;
    ent_q.neg_y  <= ngy3_q;
    ent_q.base_x <= bx3_q;
    ent_q.base_y <= by3_q;
    ent_q.found  <= fnd3_q;
  end

  // Divider chain: one quotient bit per stage.
  logic          chv [PB+1];
  lli_pkg::div_t chd [PB+1];
  assign chv[0] = v4_q;
  assign chd[0] = ent_q;

  for (genvar g = 0; g < PB; g++) begin : g_div
    lli_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chv[g]),
      .data_i  (chd[g]),
      .valid_o (chv[g+1]),
      .data_o  (chd[g+1])
    );
  end

  // Rounding to nearest, ties to even.
  lli_pkg::div_t  dq;
  logic [MB:0]    trx, try_, denw;
  logic           incx, incy;
  always_comb begin
    dq   = chd[PB];
    denw = {1'b0, dq.den};
    trx  = {dq.rem_x, 1'b0};
    try_ = {dq.rem_y, 1'b0};
    incx = (trx > denw) || ((trx == denw) && dq.quo_x[0]);
    incy = (try_ > denw) || ((try_ == denw) && dq.quo_y[0]);
  end

  logic                v5_q;
  logic [PB:0]         qrx_q, qry_q;
  logic                ngx5_q, ngy5_q, fnd5_q;
  logic signed [C-1:0] bx5_q, by5_q;

  always_ff @(posedge clk_i) begin
    qrx_q  <= (PB+1)'(dq.quo_x) + (PB+1)'(incx);
    qry_q  <= (PB+1)'(dq.quo_y) + (PB+1)'(incy);
    ngx5_q <= dq.neg_x;
    ngy5_q <= dq.neg_y;
    fnd5_q <= dq.found;
    bx5_q  <= dq.base_x;
    by5_q  <= dq.base_y;
  end

  // Clamp the quotient, add the base point, saturate to 32 bits; a parallel pair gives all zeros.
  logic [SumBits-1:0]        qcx, qcy;
  logic signed [SumBits-1:0] vx, vy;
  logic                      clx, cly;
  lli_pkg::out_t             out_d;
  always_comb begin
    qcx = (SumBits'(qrx_q) > QLimit) ? QLimit : SumBits'(qrx_q);
    qcy = (SumBits'(qry_q) > QLimit) ? QLimit : SumBits'(qry_q);
    vx  = ngx5_q ? SumBits'(bx5_q) - signed'(qcx) : SumBits'(bx5_q) + signed'(qcx);
    vy  = ngy5_q ? SumBits'(by5_q) - signed'(qcy) : SumBits'(by5_q) + signed'(qcy);
    clx = (vx > SatMax) || (vx < SatMin);
    cly = (vy > SatMax) || (vy < SatMin);
    out_d.found   = fnd5_q;
    out_d.cross_x = (vx > SatMax) ? 32'sh7fffffff :
                    (vx < SatMin) ? 32'sh80000000 : vx[31:0];
    out_d.cross_y = (vy > SatMax) ? 32'sh7fffffff :
                    (vy < SatMin) ? 32'sh80000000 : vy[31:0];
    out_d.clipped = clx || cly;
    if (!fnd5_q) begin
      out_d = '0;
    end
  end

  logic          v6_q;
  lli_pkg::out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v5_q <= chv[PB];
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o = v6_q;
  assign out_o   = out_q;

`ifndef SYNTHESIS
  // Every result traces back to an earlier accepted transaction.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, Latency))
    else $error("result without a matching accepted transaction");

  // A parallel pair reports a zero point and no clipping.
  a_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !out_o.found) |->
      (out_o.cross_x == 0 && out_o.cross_y == 0 && !out_o.clipped))
    else $error("parallel result carries a point");

  // Clipping only occurs when a coordinate sits at a 32-bit limit.
  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && out_o.clipped) |->
      (out_o.cross_x == 32'sh7fffffff || out_o.cross_x == 32'sh80000000 ||
       out_o.cross_y == 32'sh7fffffff || out_o.cross_y == 32'sh80000000))
    else $error("clipped flag without a saturated coordinate");
`endif

endmodule

`default_nettype wire

/* sv/lli_div_stage.sv */
// One stage of the restoring divider chain: develops one quotient bit for each
// coordinate and hands the record to its neighbor. Depends on lli_pkg.
`default_nettype none

module lli_div_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire lli_pkg::div_t data_i,
  output logic               valid_o,
  output lli_pkg::div_t      data_o
);

  logic [lli_pkg::MagBits:0] shx, shy, denw;
  logic                      gex, gey;
  lli_pkg::div_t             data_d;
  logic                      valid_q;
  lli_pkg::div_t             data_q;

  always_comb begin
    denw = {1'b0, data_i.den};
    shx  = {data_i.rem_x, data_i.num_x[lli_pkg::ProdBits-1]};
    shy  = {data_i.rem_y, data_i.num_y[lli_pkg::ProdBits-1]};
    gex  = shx >= denw;
    gey  = shy >= denw;
    data_d       = data_i;
    data_d.num_x = {data_i.num_x[lli_pkg::ProdBits-2:0], 1'b0};
    data_d.num_y = {data_i.num_y[lli_pkg::ProdBits-2:0], 1'b0};
    data_d.rem_x = gex ? lli_pkg::MagBits'(shx - denw) : shx[lli_pkg::MagBits-1:0];
    data_d.rem_y = gey ? lli_pkg::MagBits'(shy - denw) : shy[lli_pkg::MagBits-1:0];
    data_d.quo_x = {data_i.quo_x[lli_pkg::ProdBits-2:0], gex};
    data_d.quo_y = {data_i.quo_y[lli_pkg::ProdBits-2:0], gey};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire
